### sv/dngd_pkg.sv
// Shared types and constants for the day-number to Gregorian date converter.
// Used by every module of the block; depends on nothing.

package dngd_pkg;

    // Calendar period lengths in days
    localparam logic [17:0] DAYS_400Y   = 18'd146097;
    localparam logic [17:0] DAYS_C1     = 18'd36525;
    localparam logic [17:0] DAYS_C1C2   = 18'd73049;
    localparam logic [17:0] DAYS_C1C3   = 18'd109573;
    localparam logic [15:0] DAYS_SHORT4 = 16'd1460;
    localparam logic [10:0] DAYS_4Y     = 11'd1461;
    localparam logic [10:0] DAYS_LEAP   = 11'd366;
    localparam logic [10:0] DAYS_YEAR   = 11'd365;
    localparam logic [10:0] DAYS_2YEAR  = 11'd730;
    localparam logic [10:0] DAYS_3YEAR  = 11'd1095;

    // Lowest supported day number, 146097 * -14699
    localparam logic signed [31:0] LOW_BOUND = -32'sd2147479803;
    // Bias that moves every supported day number to a non-negative value
    localparam logic [32:0] CYCLE_OFFSET = 33'd2147479803;
    // 400-year cycle count that the bias adds
    localparam logic signed [15:0] CYCLE_BIAS = 16'sd14699;

    // floor(2^32 / 146097): quotient estimate low by at most one
    localparam logic [14:0] RECIP_400Y = 15'd29398;
    // ceil(2^26 / 1461): exact quotient for values below 2^16
    localparam logic [15:0] RECIP_4Y   = 16'd45934;

    // Month starts: common year in entries 0..11, leap year in 12..23
    localparam logic [8:0] MONTH_START [24] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334,
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    // Request after the 400-year split
    typedef struct packed {
        logic        valid;
        logic        err;
        logic [14:0] q;      // biased 400-year cycle count
        logic [17:0] n;      // day within the cycle
    } dngd_cyc_t;

    // Request after the year split
    typedef struct packed {
        logic        valid;
        logic        err;
        logic        leap;
        logic [8:0]  doy;    // day of year from 0
        logic [23:0] year;   // zero-based year, two's complement
    } dngd_date_t;

endpackage

### sv/day_number_to_gregorian_date.sv
// Top level of the day-number to proleptic Gregorian date converter.
// Depends on dngd_pkg, dngd_cycle_split, dngd_year_split, dngd_month_lookup.
//
// A request is taken on every clock edge where start is high; busy is always
// low, so a new day number may be presented every cycle. Each result appears
// in request order, on status/year/month/day for one cycle while done is
// high; the receiver must take it then. The eight stages are: three for the
// 400-year split (reciprocal multiply, remainder, correction), four for
// centuries, four-year blocks and years, and one for the month table lookup
// and output register. Day numbers below -2147479803 return status 1 with
// year, month and day at zero.

module day_number_to_gregorian_date
    import dngd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] day_number,
    output logic               done,
    output logic               status,
    output logic signed [23:0] year,
    output logic [3:0]         month,
    output logic [4:0]         day
);

    dngd_cyc_t  cyc;
    dngd_date_t date;
    logic       accept;

    // Pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    dngd_cycle_split u_cycle_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .day_number (day_number),
        .cyc        (cyc)
    );

    dngd_year_split u_year_split (
        .clk   (clk),
        .rst_n (rst_n),
        .cyc   (cyc),
        .date  (date)
    );

    dngd_month_lookup u_month_lookup (
        .clk    (clk),
        .rst_n  (rst_n),
        .date   (date),
        .done   (done),
        .status (status),
        .year   (year),
        .month  (month),
        .day    (day)
    );

endmodule

### sv/dngd_cycle_split.sv
// Splits a day number into 400-year cycles and the day within the cycle.
// Three register stages; depends on dngd_pkg.

module dngd_cycle_split
    import dngd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] day_number,
    output dngd_cyc_t          cyc
);

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s1_err_reg, s2_err_reg, s3_err_reg;
    logic [31:0] s1_u_reg;
    logic [14:0] s1_qest_reg, s2_qest_reg, s3_q_reg;
    logic [18:0] s2_r_reg;
    logic [17:0] s3_n_reg;

    logic [32:0] u_full;
    logic        err_next;
    logic [46:0] prod1;
    logic [32:0] prod2;
    logic [31:0] rem_full;
    logic        over;
    logic [18:0] r_less;
    logic [14:0] s3_q_next;
    logic [17:0] s3_n_next;

    // Stage 1: bias the day number and estimate the cycle count
    assign u_full   = {day_number[31], day_number} + CYCLE_OFFSET;
    assign err_next = day_number < LOW_BOUND;
    assign prod1    = 47'(u_full[31:0]) * 47'(RECIP_400Y);

    // Stage 2: remainder against the estimate, below twice the cycle length
    assign prod2    = 33'(s1_qest_reg) * 33'(DAYS_400Y);
    assign rem_full = s1_u_reg - prod2[31:0];

    // Stage 3: correct an estimate that came out one low
    assign over      = s2_r_reg >= 19'(DAYS_400Y);
    assign r_less    = s2_r_reg - 19'(DAYS_400Y);
    assign s3_q_next = over ? s2_qest_reg + 15'd1 : s2_qest_reg;
    assign s3_n_next = over ? r_less[17:0] : s2_r_reg[17:0];

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        s1_err_reg  <= err_next;
        s1_u_reg    <= u_full[31:0];
        s1_qest_reg <= prod1[46:32];
        s2_err_reg  <= s1_err_reg;
        s2_qest_reg <= s1_qest_reg;
        s2_r_reg    <= rem_full[18:0];
        s3_err_reg  <= s2_err_reg;
        s3_q_reg    <= s3_q_next;
        s3_n_reg    <= s3_n_next;
    end

    assign cyc.valid = s3_valid_reg;
    assign cyc.err   = s3_err_reg;
    assign cyc.q     = s3_q_reg;
    assign cyc.n     = s3_n_reg;

endmodule

### sv/dngd_year_split.sv
// Splits the day within a 400-year cycle into centuries, four-year blocks
// and years. Four register stages; depends on dngd_pkg.

module dngd_year_split
    import dngd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dngd_cyc_t  cyc,
    output dngd_date_t date
);

    logic        s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic        s4_err_reg, s5_err_reg, s6_err_reg, s7_err_reg;
    logic [23:0] s4_ybase_reg;
    logic [8:0]  s4_yoff_reg;
    logic        s4_std4_reg, s5_std4_reg;
    logic [15:0] s4_m4_reg, s5_m4_reg;
    logic [4:0]  s5_k4_reg;
    logic [23:0] s5_year_reg, s6_year_reg, s7_year_reg;
    logic        s6_leap_reg, s7_leap_reg;
    logic [10:0] s6_d_reg;
    logic [8:0]  s7_doy_reg;

    // Stage 4 signals
    logic signed [15:0] qs;
    logic signed [23:0] qs_ext;
    logic signed [23:0] ybase;
    logic [1:0]         cent;
    logic [17:0]        cent_base;
    logic [17:0]        nc_full;
    logic [15:0]        nc;
    logic               later;
    logic               short4;
    logic               std4;
    logic [15:0]        m4;
    logic [8:0]         yoff;

    // Stage 5 signals
    logic [31:0] prod4;

    // Stage 6 signals
    logic [15:0] kp;
    logic [15:0] r4_full;
    logic [10:0] r4;
    logic        leap;
    logic        plain_std;
    logic [10:0] d_next;
    logic [23:0] year6;

    // Stage 7 signals
    logic [1:0]  kk;
    logic [10:0] kk_base;
    logic [10:0] doy_full;
    logic [8:0]  doy_next;

    // Stage 4: cycle years and century split
    assign qs     = $signed({1'b0, cyc.q}) - CYCLE_BIAS;
    assign qs_ext = 24'(qs);
    assign ybase  = qs_ext * 24'sd400;

    always_comb
    begin
        priority if (cyc.n >= DAYS_C1C3)
        begin
            cent      = 2'd3;
            cent_base = DAYS_C1C3;
        end
        else if (cyc.n >= DAYS_C1C2)
        begin
            cent      = 2'd2;
            cent_base = DAYS_C1C2;
        end
        else if (cyc.n >= DAYS_C1)
        begin
            cent      = 2'd1;
            cent_base = DAYS_C1;
        end
        else
        begin
            cent      = 2'd0;
            cent_base = 18'd0;
        end
    end

    assign nc_full = cyc.n - cent_base;
    assign nc      = nc_full[15:0];
    assign later   = cent != 2'd0;
    assign short4  = later && (nc < DAYS_SHORT4);
    assign std4    = !short4;
    assign m4      = (later && std4) ? nc - DAYS_SHORT4 : nc;

    // Years from whole centuries plus the short block of a later century
    always_comb
    begin
        unique case (cent)
            2'd0:    yoff = 9'd0;
            2'd1:    yoff = 9'd100;
            2'd2:    yoff = 9'd200;
            2'd3:    yoff = 9'd300;
            default: yoff = 9'd0;
        endcase
        if (later && std4)
        begin
            yoff = yoff + 9'd4;
        end
    end

    // Stage 5: four-year block count by reciprocal
    assign prod4 = 32'(s4_m4_reg) * 32'(RECIP_4Y);

    // Stage 6: day within the block, leap year or first common year
    assign kp        = 16'(s5_k4_reg) * 16'(DAYS_4Y);
    assign r4_full   = s5_m4_reg - kp;
    assign r4        = r4_full[10:0];
    assign leap      = s5_std4_reg && (r4 < DAYS_LEAP);
    assign plain_std = s5_std4_reg && !leap;
    assign d_next    = plain_std ? r4 - DAYS_LEAP : r4;
    assign year6     = s5_year_reg + 24'({s5_k4_reg, 2'b00}) + 24'(plain_std);

    // Stage 7: split the remaining common years
    always_comb
    begin
        priority if (s6_leap_reg)
        begin
            kk      = 2'd0;
            kk_base = 11'd0;
        end
        else if (s6_d_reg >= DAYS_3YEAR)
        begin
            kk      = 2'd3;
            kk_base = DAYS_3YEAR;
        end
        else if (s6_d_reg >= DAYS_2YEAR)
        begin
            kk      = 2'd2;
            kk_base = DAYS_2YEAR;
        end
        else if (s6_d_reg >= DAYS_YEAR)
        begin
            kk      = 2'd1;
            kk_base = DAYS_YEAR;
        end
        else
        begin
            kk      = 2'd0;
            kk_base = 11'd0;
        end
    end

    assign doy_full = s6_d_reg - kk_base;
    assign doy_next = doy_full[8:0];

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= cyc.valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        s4_err_reg   <= cyc.err;
        s4_ybase_reg <= ybase;
        s4_yoff_reg  <= yoff;
        s4_std4_reg  <= std4;
        s4_m4_reg    <= m4;

        s5_err_reg   <= s4_err_reg;
        s5_std4_reg  <= s4_std4_reg;
        s5_m4_reg    <= s4_m4_reg;
        s5_k4_reg    <= prod4[30:26];
        s5_year_reg  <= s4_ybase_reg + 24'(s4_yoff_reg);

        s6_err_reg   <= s5_err_reg;
        s6_leap_reg  <= leap;
        s6_d_reg     <= d_next;
        s6_year_reg  <= year6;

        s7_err_reg   <= s6_err_reg;
        s7_leap_reg  <= s6_leap_reg;
        s7_doy_reg   <= doy_next;
        s7_year_reg  <= s6_year_reg + 24'(kk);
    end

    assign date.valid = s7_valid_reg;
    assign date.err   = s7_err_reg;
    assign date.leap  = s7_leap_reg;
    assign date.doy   = s7_doy_reg;
    assign date.year  = s7_year_reg;

endmodule

### sv/dngd_month_lookup.sv
// Finds month and day from the day of year, skips year zero and registers
// the result. One register stage; depends on dngd_pkg.

module dngd_month_lookup
    import dngd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dngd_date_t         date,
    output logic               done,
    output logic               status,
    output logic signed [23:0] year,
    output logic [3:0]         month,
    output logic [4:0]         day
);

    logic              done_reg;
    logic              status_reg;
    logic [23:0]       year_reg;
    logic [3:0]        month_reg;
    logic [4:0]        day_reg;

    logic [4:0]        base_idx;
    logic [3:0]        m;
    logic [8:0]        mstart;
    logic [8:0]        dom;
    logic signed [23:0] yr;
    logic [23:0]       year_next;
    logic [3:0]        month_next;
    logic [4:0]        day_next;

    // Count month starts at or below the day of year
    assign base_idx = date.leap ? 5'd12 : 5'd0;

    always_comb
    begin
        m = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (date.doy >= MONTH_START[base_idx + 5'(i)])
            begin
                m = m + 4'd1;
            end
        end
    end

    assign mstart = MONTH_START[base_idx + 5'(m)];
    assign dom    = date.doy - mstart + 9'd1;

    // Drop year zero: zero-based years at or below zero move one lower
    assign yr = $signed(date.year);

    always_comb
    begin
        if (date.err)
        begin
            year_next  = 24'd0;
            month_next = 4'd0;
            day_next   = 5'd0;
        end
        else
        begin
            year_next  = (yr <= 24'sd0) ? date.year - 24'd1 : date.year;
            month_next = m + 4'd1;
            day_next   = dom[4:0];
        end
    end

    // Hold the strobe for one cycle per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= date.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= date.err;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign year   = $signed(year_reg);
    assign month  = month_reg;
    assign day    = day_reg;

endmodule
